// ----- rtl/core/mkst_pkg.sv -----
// Shared types and constants for the masked key set table.
// Used by the cell chain, the top level and the port checker.
package mkst_pkg;

  // Table geometry
  localparam int CAPACITY = 255;
  localparam int CNT_W    = 8;
  localparam int LIMIT    = (CAPACITY < 255) ? CAPACITY : 255;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W    = (IDX_W > CNT_W) ? IDX_W : CNT_W;

  // Field widths
  localparam int REQ_W = 2;
  localparam int KEY_W = 32;
  localparam int TAG_W = 30;

  // Request codes (code 3 behaves as a query)
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic             success;
    logic [CNT_W-1:0] count;
  } out_item_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic             rotate;
    logic             del_en;
    logic             ins_en;
    logic [IDX_W-1:0] pos;
    logic [TAG_W-1:0] tag;
  } cell_ctl_t;

endpackage

// ----- rtl/core/masked_key_set_table.sv -----
// Masked key set table: a ring of tag cells scanned by rotation.
// Requests are taken one at a time: in_ready is high only while idle, so
// no new request enters until the full rotation of the cell ring for the
// compare pass and the update step (held while a result stalls) are done.
// Reset (rst_n low, synchronous) empties the table and drops out_valid;
// cell contents are not cleared and are never read past the entry count.
module masked_key_set_table (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mkst_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mkst_pkg::out_item_t  out_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  localparam logic [mkst_pkg::IDX_W-1:0] LAST_STEP = mkst_pkg::IDX_W'(mkst_pkg::CAPACITY - 1);
  localparam logic [mkst_pkg::CNT_W-1:0] LIMIT_CNT = mkst_pkg::CNT_W'(mkst_pkg::LIMIT);

  logic [1:0]                    state_r, state_nxt;
  logic [mkst_pkg::IDX_W-1:0]    step_r, step_nxt;
  logic [mkst_pkg::IDX_W-1:0]    pos_r, pos_nxt;
  logic                          hit_r, hit_nxt;
  logic [mkst_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [mkst_pkg::REQ_W-1:0]    req_r;
  logic [mkst_pkg::TAG_W-1:0]    tag_r;
  logic                          out_valid_r, out_valid_nxt;
  mkst_pkg::out_item_t           out_data_r, out_data_nxt;

  mkst_pkg::cell_ctl_t           ctl;
  logic [mkst_pkg::TAG_W-1:0]    cell_data [mkst_pkg::CAPACITY];
  logic                          in_xfer;
  logic                          out_free;
  logic                          head_match;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // head cell holds entry number step_r during the scan
  assign head_match = (cell_data[0] == tag_r) &&
                      ((mkst_pkg::CMP_W)'(step_r) < (mkst_pkg::CMP_W)'(count_r));

  // sequencer, table update and result formation
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    pos_nxt       = pos_r;
    hit_nxt       = hit_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ctl           = '0;
    ctl.tag       = tag_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_SCAN;
          step_nxt  = '0;
          hit_nxt   = 1'b0;
          pos_nxt   = '0;
        end
      end
      S_SCAN: begin
        ctl.rotate = 1'b1;
        if (!hit_r && head_match) begin
          hit_nxt = 1'b1;
          pos_nxt = step_r;
        end
        if (step_r == LAST_STEP) begin
          state_nxt = S_UPD;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_UPD: begin
        if (out_free) begin
          out_data_nxt.hit = hit_r;
          case (req_r)
            mkst_pkg::REQ_INSERT: begin
              if (hit_r) begin
                out_data_nxt.success = 1'b1;
              end else if (count_r < LIMIT_CNT) begin
                ctl.ins_en           = 1'b1;
                ctl.pos              = mkst_pkg::IDX_W'(count_r);
                count_nxt            = count_r + 1'b1;
                out_data_nxt.success = 1'b1;
              end else begin
                out_data_nxt.success = 1'b0;
              end
            end
            mkst_pkg::REQ_DELETE: begin
              if (hit_r) begin
                ctl.del_en = 1'b1;
                ctl.pos    = pos_r;
                count_nxt  = count_r - 1'b1;
              end
              out_data_nxt.success = 1'b1;
            end
            default: begin
              out_data_nxt.success = hit_r;
            end
          endcase
          out_data_nxt.count = count_nxt;
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      pos_r       <= '0;
      hit_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      pos_r       <= pos_nxt;
      hit_r       <= hit_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r <= in_data.req_type;
      tag_r <= in_data.key[mkst_pkg::KEY_W-1:2];
    end
    out_data_r <= out_data_nxt;
  end

  // ring of cells: each cell takes its upper neighbor, the last wraps to cell 0
  for (genvar i = 0; i < mkst_pkg::CAPACITY; i++) begin : g_cell
    mkst_cell u_cell (
      .clk      (clk),
      .idx      (mkst_pkg::IDX_W'(i)),
      .ctl      (ctl),
      .nbr_data (cell_data[(i + 1) % mkst_pkg::CAPACITY]),
      .data     (cell_data[i])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/mkst_cell.sv -----
// One storage cell of the table chain: holds a single 30-bit tag.
// Depends on mkst_pkg for the control struct and widths.
module mkst_cell (
  input  logic                            clk,
  input  logic [mkst_pkg::IDX_W-1:0]      idx,
  input  mkst_pkg::cell_ctl_t             ctl,
  input  logic [mkst_pkg::TAG_W-1:0]      nbr_data,
  output logic [mkst_pkg::TAG_W-1:0]      data
);

  logic [mkst_pkg::TAG_W-1:0] data_r;
  logic [mkst_pkg::TAG_W-1:0] data_nxt;

  // rotate during scan, close the gap on delete, take the tag on insert
  always_comb begin
    data_nxt = data_r;
    if (ctl.rotate) begin
      data_nxt = nbr_data;
    end else if (ctl.del_en && (idx >= ctl.pos)) begin
      data_nxt = nbr_data;
    end else if (ctl.ins_en && (idx == ctl.pos)) begin
      data_nxt = ctl.tag;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ----- rtl/core/mkst_chk.sv -----
// Port-level checker for the masked key set table, bound to the top level.
// Depends on mkst_pkg for the payload types and the entry limit.
module mkst_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input mkst_pkg::in_item_t   in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input mkst_pkg::out_item_t  out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // entry count never exceeds the table limit
  a_count_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.count <= mkst_pkg::CNT_W'(mkst_pkg::LIMIT)))
    else $error("entry count above limit");

  // a hit always reports success
  a_hit_succ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.success)
    else $error("hit without success");

  // one request at a time: busy right after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // reset drops the result valid
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind masked_key_set_table mkst_chk u_mkst_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
